// ===== src/sdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared types and constants of the SD card SPI-mode host.
// ----------------------------------------------------------------------------
package sdh_pkg;

  localparam int unsigned InW  = 56;
  localparam int unsigned OutW = 40;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_CARD  = 3'd3,
    REQ_WDATA = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CFG_POWERUP = 3'd0,
    CFG_RESP    = 3'd1,
    CFG_IDLE    = 3'd2,
    CFG_OPCOND  = 3'd3,
    CFG_TOKEN   = 3'd4,
    CFG_WRITE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_POWERUP, PH_CMD, PH_RESP, PH_R7, PH_OCR, PH_INIT_TAIL,
    PH_RD_TOKEN, PH_RD_DATA, PH_RD_TRAIL,
    PH_WR_READY, PH_WR_TOKEN, PH_WR_REQ, PH_WR_DATA, PH_WR_CRC,
    PH_WR_RESP, PH_WR_BUSY, PH_WR_TAIL
  } phase_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_IDLE  = 4'd1;
  localparam logic [3:0] ST_BAD_VOLT = 4'd2;
  localparam logic [3:0] ST_NOT_SD   = 4'd3;
  localparam logic [3:0] ST_INIT_TO  = 4'd4;
  localparam logic [3:0] ST_REJECTED = 4'd5;
  localparam logic [3:0] ST_NO_TOKEN = 4'd6;
  localparam logic [3:0] ST_NO_WRESP = 4'd7;
  localparam logic [3:0] ST_BUSY_TO  = 4'd8;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_READ     = 6'd17;
  localparam logic [5:0] CMD_WRITE    = 6'd24;
  localparam logic [5:0] CMD_OPCOND   = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  typedef struct packed {
    logic [7:0]  powerup;
    logic [7:0]  resp;
    logic [9:0]  idle;
    logic [15:0] opcond;
    logic [23:0] token;
    logic [23:0] wr;
  } cfg_t;

  typedef struct packed {
    logic [1:0] card_type;
    logic [3:0] status;
    logic       done_res;
    logic       data_request;
    logic       rd_last;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } res_t;

endpackage : sdh_pkg
`default_nettype wire

// ===== src/sd_card_spi_host_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_card_spi_host_controller
// Byte-level SD card host sequencer for SPI mode.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ stream is one request: start init, read sector,
//   write sector, a byte received from the card, or a write data byte. Each
//   request yields exactly one transfer on the out_ stream carrying the next
//   byte to shift out, read data with a last mark, a data request, done with
//   status, the card type and the clock speed select.
//   cfg_ writes set the poll and retry limits; write them only while idle.
// Timing:
//   A request is registered at its transfer; its result sits in the output
//   register in the next cycle. One request per cycle is taken while the output
//   register is empty or being drained at the same edge. The SPI byte
//   exchange itself paces real traffic.
// Reset:
//   Sequencer idle, card type unknown, slow clock, limits at their defaults.
// Stall:
//   With out_tready low and a result held, in_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module sd_card_spi_host_controller #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // [2:0] req_type, [34:3] sector, [42:35] rx_byte, [50:43] wr_byte
  input  wire logic [sdh_pkg::InW-1:0] in_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] rd_valid, [17:10] rd_byte, [18] rd_last,
  // [19] data_request, [20] done_res, [24:21] status, [26:25] card_type,
  // [27] slow_clock
  output logic [sdh_pkg::OutW-1:0]     out_tdata,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [23:0]             cfg_data
);
  sdh_pkg::cfg_t lim;
  sdh_pkg::res_t res;
  logic          slow;
  logic          step;
  logic          out_valid_r;
  logic [27:0]   out_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  sdh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .lim     (lim)
  );

  sdh_core #(.SECTOR_BYTES(SECTOR_BYTES)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .req_type (in_tdata[2:0]),
    .sector   (in_tdata[34:3]),
    .rx_byte  (in_tdata[42:35]),
    .wr_byte  (in_tdata[50:43]),
    .lim      (lim),
    .res      (res),
    .slow     (slow)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {slow, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {12'd0, out_data_r};
endmodule : sd_card_spi_host_controller
`default_nettype wire

// ===== src/sdh_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_cfg
// Limit registers; a zero write reads back as one.
// ----------------------------------------------------------------------------
module sdh_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [2:0]    wr_idx,
  input  wire logic [23:0]   wr_data,
  output sdh_pkg::cfg_t      lim
);
  sdh_pkg::cfg_t cfg_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.powerup <= 8'd10;
      cfg_r.resp    <= 8'd10;
      cfg_r.idle    <= 10'd100;
      cfg_r.opcond  <= 16'd1000;
      cfg_r.token   <= 24'd200000;
      cfg_r.wr      <= 24'd1000000;
    end else if (wr_en) begin
      case (wr_idx)
        sdh_pkg::CFG_POWERUP: cfg_r.powerup <= wr_data[7:0];
        sdh_pkg::CFG_RESP:    cfg_r.resp    <= wr_data[7:0];
        sdh_pkg::CFG_IDLE:    cfg_r.idle    <= wr_data[9:0];
        sdh_pkg::CFG_OPCOND:  cfg_r.opcond  <= wr_data[15:0];
        sdh_pkg::CFG_TOKEN:   cfg_r.token   <= wr_data;
        sdh_pkg::CFG_WRITE:   cfg_r.wr      <= wr_data;
        default: ;
      endcase
    end
  end

  // zero acts as one
  always_comb begin
    lim = cfg_r;
    if (cfg_r.powerup == '0) lim.powerup = 8'd1;
    if (cfg_r.resp == '0)    lim.resp    = 8'd1;
    if (cfg_r.idle == '0)    lim.idle    = 10'd1;
    if (cfg_r.opcond == '0)  lim.opcond  = 16'd1;
    if (cfg_r.token == '0)   lim.token   = 24'd1;
    if (cfg_r.wr == '0)      lim.wr      = 24'd1;
  end
endmodule : sdh_cfg
`default_nettype wire

// ===== src/sdh_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_core
// Protocol sequencer: one request in, one result out, state updated per step.
// ----------------------------------------------------------------------------
module sdh_core #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [2:0]    req_type,
  input  wire logic [31:0]   sector,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    wr_byte,
  input  sdh_pkg::cfg_t      lim,
  output sdh_pkg::res_t      res,
  output logic               slow
);
  localparam int unsigned CW = $clog2(SECTOR_BYTES + 1);
  localparam logic [CW-1:0] SecCnt = CW'(SECTOR_BYTES);

  sdh_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [23:0]     retry_r, retry_nxt, retry_inc;
  logic [1:0]      kind_r, kind_nxt;
  logic [5:0]      cidx_r, cidx_nxt;
  logic [31:0]     carg_r, carg_nxt;
  logic [7:0]      reply_r [4];
  logic [7:0]      reply0_nxt, reply2_nxt;
  logic            slow_r, slow_nxt;
  logic [CW-1:0]   cnt_inc;
  logic [7:0]      frame;
  logic [7:0]      rx;

  assign rx        = rx_byte;
  assign cnt_inc   = cnt_r + 1'b1;
  assign retry_inc = retry_r + 1'b1;

  // command frame byte for count cnt_inc
  always_comb begin
    case (cnt_inc[2:0])
      3'd1:    frame = {2'b01, cidx_r};
      3'd2:    frame = carg_r[31:24];
      3'd3:    frame = carg_r[23:16];
      3'd4:    frame = carg_r[15:8];
      3'd5:    frame = carg_r[7:0];
      default: frame = (cidx_r == sdh_pkg::CMD_GO_IDLE) ? 8'h95 :
                       (cidx_r == sdh_pkg::CMD_IF_COND) ? 8'h87 : 8'h01;
    endcase
  end

  // next state and result
  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; retry_nxt = retry_r;
    kind_nxt = kind_r; cidx_nxt = cidx_r; carg_nxt = carg_r;
    slow_nxt = slow_r; reply0_nxt = reply_r[0]; reply2_nxt = reply_r[2];
    res = '0;
    case (req_type)
      sdh_pkg::REQ_INIT, sdh_pkg::REQ_READ, sdh_pkg::REQ_WRITE: begin
        if (phase_r == sdh_pkg::PH_IDLE) begin
          res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
          if (req_type == sdh_pkg::REQ_INIT) begin
            kind_nxt = 2'd0; slow_nxt = 1'b1;
            phase_nxt = sdh_pkg::PH_POWERUP; cnt_nxt = CW'(1);
          end else begin
            carg_nxt = (kind_r != 2'd3) ? {sector[22:0], 9'd0} : sector;
            if (req_type == sdh_pkg::REQ_WRITE) slow_nxt = 1'b1;
            cidx_nxt = (req_type == sdh_pkg::REQ_READ) ? sdh_pkg::CMD_READ
                                                       : sdh_pkg::CMD_WRITE;
            phase_nxt = sdh_pkg::PH_CMD; cnt_nxt = '0;
          end
        end
      end
      sdh_pkg::REQ_WDATA: begin
        if (phase_r == sdh_pkg::PH_WR_REQ) begin
          phase_nxt = sdh_pkg::PH_WR_DATA;
          res.tx_valid = 1'b1; res.tx_byte = wr_byte;
        end
      end
      sdh_pkg::REQ_CARD: begin
        res.tx_byte = 8'hFF;
        res.tx_valid = (phase_r != sdh_pkg::PH_IDLE) &&
                       (phase_r != sdh_pkg::PH_WR_REQ);
        case (phase_r)
          sdh_pkg::PH_POWERUP: begin
            if (cnt_r < CW'(lim.powerup)) cnt_nxt = cnt_inc;
            else begin
              retry_nxt = 24'd1; cidx_nxt = sdh_pkg::CMD_GO_IDLE; carg_nxt = '0;
              phase_nxt = sdh_pkg::PH_CMD; cnt_nxt = '0;
            end
          end
          sdh_pkg::PH_CMD: begin
            if (cnt_r < CW'(6)) begin
              cnt_nxt = cnt_inc; res.tx_byte = frame;
            end else begin
              phase_nxt = sdh_pkg::PH_RESP; cnt_nxt = '0;
            end
          end
          sdh_pkg::PH_RESP: begin
            cnt_nxt = cnt_inc;
            if (!(rx[7] && cnt_inc < CW'(lim.resp))) begin
              // command complete
              phase_nxt = sdh_pkg::PH_CMD; cnt_nxt = '0;
              case (cidx_r)
                sdh_pkg::CMD_GO_IDLE: begin
                  if (rx == 8'h01) begin
                    cidx_nxt = sdh_pkg::CMD_IF_COND; carg_nxt = 32'h0000_01AA;
                  end else if (retry_r >= 24'(lim.idle)) begin
                    phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                    res.done_res = 1'b1; res.status = sdh_pkg::ST_NO_IDLE;
                  end else begin
                    retry_nxt = retry_inc; carg_nxt = '0;
                  end
                end
                sdh_pkg::CMD_IF_COND: begin
                  if (rx == 8'h01) phase_nxt = sdh_pkg::PH_R7;
                  else begin
                    kind_nxt = 2'd1; retry_nxt = 24'd1;
                    cidx_nxt = sdh_pkg::CMD_APP; carg_nxt = '0;
                  end
                end
                sdh_pkg::CMD_APP: begin
                  if (rx > 8'h01) begin
                    phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                    res.done_res = 1'b1; res.status = sdh_pkg::ST_NOT_SD;
                  end else begin
                    cidx_nxt = sdh_pkg::CMD_OPCOND;
                    carg_nxt = (kind_r == 2'd2) ? 32'h4000_0000 : '0;
                  end
                end
                sdh_pkg::CMD_OPCOND: begin
                  if (rx == 8'h00) begin
                    if (kind_r == 2'd2) begin
                      cidx_nxt = sdh_pkg::CMD_READ_OCR; carg_nxt = '0;
                    end else phase_nxt = sdh_pkg::PH_INIT_TAIL;
                  end else if (retry_r >= 24'(lim.opcond)) begin
                    phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                    res.done_res = 1'b1; res.status = sdh_pkg::ST_INIT_TO;
                  end else begin
                    retry_nxt = retry_inc; cidx_nxt = sdh_pkg::CMD_APP;
                    carg_nxt = '0;
                  end
                end
                sdh_pkg::CMD_READ_OCR: begin
                  phase_nxt = (rx == 8'h00) ? sdh_pkg::PH_OCR
                                            : sdh_pkg::PH_INIT_TAIL;
                end
                sdh_pkg::CMD_READ: begin
                  if (rx != 8'h00) begin
                    phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                    res.done_res = 1'b1; res.status = sdh_pkg::ST_REJECTED;
                  end else begin
                    phase_nxt = sdh_pkg::PH_RD_TOKEN; retry_nxt = '0;
                  end
                end
                default: begin
                  if (rx != 8'h00) begin
                    slow_nxt = 1'b0;
                    phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                    res.done_res = 1'b1; res.status = sdh_pkg::ST_REJECTED;
                  end else begin
                    phase_nxt = sdh_pkg::PH_WR_READY; retry_nxt = '0;
                  end
                end
              endcase
            end
          end
          sdh_pkg::PH_R7, sdh_pkg::PH_OCR: begin
            cnt_nxt = cnt_inc;
            if (cnt_r[1:0] == 2'd0) reply0_nxt = rx;
            if (cnt_r[1:0] == 2'd2) reply2_nxt = rx;
            if (cnt_inc >= CW'(4)) begin
              // reply[3] is this byte
              if (phase_r == sdh_pkg::PH_R7) begin
                if (reply_r[2] == 8'h01 && rx == 8'hAA) begin
                  kind_nxt = 2'd2; retry_nxt = 24'd1;
                  cidx_nxt = sdh_pkg::CMD_APP; carg_nxt = '0;
                  phase_nxt = sdh_pkg::PH_CMD; cnt_nxt = '0;
                end else begin
                  phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
                  res.done_res = 1'b1; res.status = sdh_pkg::ST_BAD_VOLT;
                end
              end else begin
                if (reply_r[0][6]) kind_nxt = 2'd3;
                phase_nxt = sdh_pkg::PH_INIT_TAIL;
              end
            end
          end
          sdh_pkg::PH_INIT_TAIL, sdh_pkg::PH_WR_TAIL: begin
            slow_nxt = 1'b0; phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
            res.done_res = 1'b1; res.status = sdh_pkg::ST_OK;
          end
          sdh_pkg::PH_RD_TOKEN: begin
            retry_nxt = retry_inc;
            if (rx == 8'hFF && retry_inc < lim.token) ;
            else if (rx == 8'hFE) begin
              phase_nxt = sdh_pkg::PH_RD_DATA; cnt_nxt = '0;
            end else begin
              phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
              res.done_res = 1'b1; res.status = sdh_pkg::ST_NO_TOKEN;
            end
          end
          sdh_pkg::PH_RD_DATA: begin
            res.rd_valid = 1'b1; res.rd_byte = rx; cnt_nxt = cnt_inc;
            if (cnt_inc >= SecCnt) begin
              res.rd_last = 1'b1; phase_nxt = sdh_pkg::PH_RD_TRAIL;
              cnt_nxt = CW'(1);
            end
          end
          sdh_pkg::PH_RD_TRAIL: begin
            if (cnt_r < CW'(3)) cnt_nxt = cnt_inc;
            else begin
              phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
              res.done_res = 1'b1; res.status = sdh_pkg::ST_OK;
            end
          end
          sdh_pkg::PH_WR_READY: begin
            retry_nxt = retry_inc;
            if (rx == 8'hFF) begin
              phase_nxt = sdh_pkg::PH_WR_TOKEN; res.tx_byte = 8'hFE;
            end else if (retry_inc < lim.wr) ;
            else begin
              slow_nxt = 1'b0; phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
              res.done_res = 1'b1; res.status = sdh_pkg::ST_BUSY_TO;
            end
          end
          sdh_pkg::PH_WR_TOKEN: begin
            phase_nxt = sdh_pkg::PH_WR_REQ; cnt_nxt = '0;
            res.tx_valid = 1'b0; res.data_request = 1'b1;
          end
          sdh_pkg::PH_WR_DATA: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc < SecCnt) begin
              phase_nxt = sdh_pkg::PH_WR_REQ; res.tx_valid = 1'b0;
              res.data_request = 1'b1;
            end else begin
              phase_nxt = sdh_pkg::PH_WR_CRC; cnt_nxt = CW'(1);
            end
          end
          sdh_pkg::PH_WR_CRC: begin
            if (cnt_r < CW'(2)) cnt_nxt = cnt_inc;
            else begin
              phase_nxt = sdh_pkg::PH_WR_RESP; retry_nxt = '0;
            end
          end
          sdh_pkg::PH_WR_RESP: begin
            retry_nxt = retry_inc;
            if (rx[4:0] == 5'h05) begin
              phase_nxt = sdh_pkg::PH_WR_BUSY; retry_nxt = '0;
            end else if (retry_inc < lim.wr) ;
            else begin
              slow_nxt = 1'b0; phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
              res.done_res = 1'b1; res.status = sdh_pkg::ST_NO_WRESP;
            end
          end
          sdh_pkg::PH_WR_BUSY: begin
            retry_nxt = retry_inc;
            if (rx != 8'h00) phase_nxt = sdh_pkg::PH_WR_TAIL;
            else if (retry_inc < lim.wr) ;
            else begin
              slow_nxt = 1'b0; phase_nxt = sdh_pkg::PH_IDLE; res.tx_valid = 1'b0;
              res.done_res = 1'b1; res.status = sdh_pkg::ST_BUSY_TO;
            end
          end
          default: res.tx_valid = 1'b0;
        endcase
        if (!res.tx_valid) res.tx_byte = 8'h00;
      end
      default: ;
    endcase
    res.card_type = kind_nxt;
  end

  assign slow = slow_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdh_pkg::PH_IDLE;
      cnt_r   <= '0;
      retry_r <= '0;
      kind_r  <= '0;
      cidx_r  <= '0;
      carg_r  <= '0;
      slow_r  <= 1'b1;
      for (int i = 0; i < 4; i++) reply_r[i] <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      retry_r    <= retry_nxt;
      kind_r     <= kind_nxt;
      cidx_r     <= cidx_nxt;
      carg_r     <= carg_nxt;
      slow_r     <= slow_nxt;
      reply_r[0] <= reply0_nxt;
      reply_r[2] <= reply2_nxt;
    end
  end
endmodule : sdh_core
`default_nettype wire
